>>> hdl/lrld_pkg.sv
// ----------------------------------------------------------------------------
// Light ring line detector package
// Shared constants, controller states and the search result record.
// ----------------------------------------------------------------------------
package lrld_pkg;

  localparam int SENSOR_COUNT   = 32;
  localparam int RING_POSITIONS = 16;
  localparam int SAMPLE_BITS    = 12;

  localparam int IDX_W  = 5;
  localparam int POS_W  = $clog2(RING_POSITIONS);
  localparam int SPAN_W = $clog2(RING_POSITIONS / 2 + 1);
  localparam int BIS_W  = $clog2(2 * RING_POSITIONS);

  localparam int DATA_W     = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_SEL_W  = CFG_ADDR_W - 2;

  localparam logic [CFG_SEL_W-1:0]   REG_THRESHOLD = '0;
  localparam logic [SAMPLE_BITS-1:0] THRESH_RESET  = SAMPLE_BITS'(500);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DELIVER
  } ctl_state_t;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  end_pos;
    logic [SPAN_W-1:0] span;
  } search_res_t;

endpackage

>>> hdl/light_ring_line_detector_top.sv
// ----------------------------------------------------------------------------
// Light ring line detector
// Thresholds light-sensor samples into ring position flags and, at the end
// of each frame, reports the widest pair of lit positions on the ring.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake           Moves
//   in_       to block    in_valid/in_stall   one sample request
//   out_      from block  out_valid/out_stall one line result per frame end
//   cfg       to block    APB psel/penable    light threshold register
//
// A sample request without the frame-end mark has its flag updated at the
// accepting edge, and the next request can follow at once.
// A frame-end request starts the pair search, which steps one pair of ring
// positions per cycle through the single gap compare unit; the input
// stays stalled through the search and its hand-off. The result then sits
// in an output register that holds steady while out_stall is high; the
// input reopens as soon as the result is loaded there. Reset clears the
// flags and loads the default threshold of 500.
// ----------------------------------------------------------------------------
module light_ring_line_detector_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Sample input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [lrld_pkg::SAMPLE_BITS-1:0]      in_sample,
  input  logic [lrld_pkg::IDX_W-1:0]            in_sensor_index,
  input  logic                                  in_frame_end,
  // Result output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_line_found,
  output logic [lrld_pkg::POS_W-1:0]            out_start_position,
  output logic [lrld_pkg::POS_W-1:0]            out_end_position,
  output logic [lrld_pkg::BIS_W-1:0]            out_bisector_step,
  output logic [lrld_pkg::SPAN_W-1:0]           out_span_eighths,
  // Configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [lrld_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [lrld_pkg::DATA_W-1:0]           pwdata,
  output logic [lrld_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);

  localparam int RING  = lrld_pkg::RING_POSITIONS;
  localparam int POS_W = lrld_pkg::POS_W;
  localparam int BIS_W = lrld_pkg::BIS_W;

  lrld_pkg::ctl_state_t state_r, state_nxt;

  logic [lrld_pkg::SAMPLE_BITS-1:0] thresh_r, thresh_nxt;
  logic [RING-1:0]                  hits_r, hits_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic                             found_r;
  logic [POS_W-1:0]                 start_r;
  logic [POS_W-1:0]                 end_r;
  logic [BIS_W-1:0]                 bis_r;
  logic [lrld_pkg::SPAN_W-1:0]      span_r;

  logic                             in_accept;
  logic                             cfg_write;
  logic                             search_start;
  logic                             search_done;
  logic                             out_load;
  logic [POS_W-1:0]                 pos;
  logic                             pos_valid;
  lrld_pkg::search_res_t            res;

  // --------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; no wait states.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    thresh_nxt = thresh_r;
    if (cfg_write && (paddr[lrld_pkg::CFG_ADDR_W-1:2] == lrld_pkg::REG_THRESHOLD)) begin
      thresh_nxt = pwdata[lrld_pkg::SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[lrld_pkg::CFG_ADDR_W-1:2] == lrld_pkg::REG_THRESHOLD) begin
      prdata = lrld_pkg::DATA_W'(thresh_r);
    end
  end

  // --------------------------------------------------------------------------
  // Position flags. An even sensor index 2k drives ring position k; odd
  // indices and indices past the ring leave every flag alone.
  // --------------------------------------------------------------------------
  assign in_accept = in_valid && !in_stall;
  assign pos       = in_sensor_index[POS_W:1];
  assign pos_valid = !in_sensor_index[0] &&
                     (int'(in_sensor_index) < lrld_pkg::SENSOR_COUNT) &&
                     (int'(pos) < RING);

  always_comb begin
    hits_nxt = hits_r;
    if (in_accept && pos_valid) begin
      hits_nxt[pos] = (in_sample >= thresh_r);
    end
  end

  // --------------------------------------------------------------------------
  // Pair search. Flags cannot change while it runs because the input is
  // stalled for the whole search.
  // --------------------------------------------------------------------------
  lrld_pair_search u_search (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (search_start),
    .hits   (hits_r),
    .done   (search_done),
    .res    (res)
  );

  // --------------------------------------------------------------------------
  // Controller: next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lrld_pkg::ST_IDLE: begin
        if (in_accept && in_frame_end) begin
          state_nxt = lrld_pkg::ST_SEARCH;
        end
      end
      lrld_pkg::ST_SEARCH: begin
        if (search_done) begin
          state_nxt = lrld_pkg::ST_DELIVER;
        end
      end
      lrld_pkg::ST_DELIVER: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = lrld_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lrld_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller: outputs.
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall     = 1'b1;
    search_start = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      lrld_pkg::ST_IDLE: begin
        in_stall     = 1'b0;
        search_start = in_valid && in_frame_end;
      end
      lrld_pkg::ST_SEARCH: begin
        in_stall = 1'b1;
      end
      lrld_pkg::ST_DELIVER: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register. A held result stays put until the consumer takes it.
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrld_pkg::ST_IDLE;
      thresh_r    <= lrld_pkg::THRESH_RESET;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      thresh_r    <= thresh_nxt;
      hits_r      <= hits_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      found_r <= res.found;
      start_r <= res.start_pos;
      end_r   <= res.end_pos;
      // The bisector wraps at twice the ring size, which the width does.
      bis_r   <= BIS_W'({res.start_pos, 1'b0}) + BIS_W'(res.span);
      span_r  <= res.span;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_line_found     = found_r;
  assign out_start_position = start_r;
  assign out_end_position   = end_r;
  assign out_bisector_step  = bis_r;
  assign out_span_eighths   = span_r;

`ifndef SYNTHESIS
  // A new result only appears out of the delivery state.
  a_rise_from_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == lrld_pkg::ST_DELIVER))
    else $error("result appeared outside delivery");

  // A found line always has its end above its start and a nonzero span.
  a_found_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_found) |->
      ((out_end_position > out_start_position) && (out_span_eighths != '0)))
    else $error("found line with bad pair");

  // No line means an all-zero result.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_line_found) |->
      ((out_span_eighths == '0) && (out_start_position == '0) &&
       (out_end_position == '0) && (out_bisector_step == '0)))
    else $error("empty result not cleared");
`endif

endmodule

>>> hdl/lrld_gap_unit.sv
// ----------------------------------------------------------------------------
// Ring gap compare unit
// Circular distance between two ring positions and a compare against the
// best distance found so far.
// ----------------------------------------------------------------------------
module lrld_gap_unit (
  input  logic [lrld_pkg::POS_W-1:0]  pos_lo,
  input  logic [lrld_pkg::POS_W-1:0]  pos_hi,
  input  logic [lrld_pkg::SPAN_W-1:0] best,
  output logic [lrld_pkg::SPAN_W-1:0] gap,
  output logic                        wider
);

  localparam int W = lrld_pkg::POS_W + 1;

  logic [W-1:0] raw_gap;
  logic [W-1:0] wrapped;

  // The two positions are distinct and ordered, so the raw distance is at
  // least one and below the ring size.
  always_comb begin
    raw_gap = W'(pos_hi) - W'(pos_lo);
    wrapped = (raw_gap > W'(lrld_pkg::RING_POSITIONS / 2)) ?
              (W'(lrld_pkg::RING_POSITIONS) - raw_gap) : raw_gap;
    gap     = lrld_pkg::SPAN_W'(wrapped);
    wider   = (gap > best);
  end

endmodule

>>> hdl/lrld_pair_search.sv
// ----------------------------------------------------------------------------
// Pair search sequencer
// Walks every pair i < j of ring positions, one pair per cycle, through
// the shared gap compare unit and keeps the first widest pair.
// ----------------------------------------------------------------------------
module lrld_pair_search (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [lrld_pkg::RING_POSITIONS-1:0]     hits,
  output logic                                    done,
  output lrld_pkg::search_res_t                   res
);

  localparam int POS_W  = lrld_pkg::POS_W;
  localparam int SPAN_W = lrld_pkg::SPAN_W;

  logic              active_r, active_nxt;
  logic              done_r, done_nxt;
  logic [POS_W-1:0]  i_r, i_nxt;
  logic [POS_W-1:0]  j_r, j_nxt;
  logic [SPAN_W-1:0] best_r, best_nxt;
  logic [POS_W-1:0]  s_r, s_nxt;
  logic [POS_W-1:0]  e_r, e_nxt;
  logic              found_r, found_nxt;

  logic [SPAN_W-1:0] gap;
  logic              wider;
  logic              last_j;
  logic              last_i;

  lrld_gap_unit u_gap (
    .pos_lo (i_r),
    .pos_hi (j_r),
    .best   (best_r),
    .gap    (gap),
    .wider  (wider)
  );

  assign last_j = (j_r == POS_W'(lrld_pkg::RING_POSITIONS - 1));
  assign last_i = (i_r == POS_W'(lrld_pkg::RING_POSITIONS - 2));

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    i_nxt      = i_r;
    j_nxt      = j_r;
    best_nxt   = best_r;
    s_nxt      = s_r;
    e_nxt      = e_r;
    found_nxt  = found_r;
    if (start) begin
      active_nxt = 1'b1;
      i_nxt      = '0;
      j_nxt      = POS_W'(1);
      best_nxt   = '0;
      s_nxt      = '0;
      e_nxt      = '0;
      found_nxt  = 1'b0;
    end else if (active_r) begin
      // Strictly wider keeps the earliest pair on a tie.
      if (hits[i_r] && hits[j_r] && wider) begin
        best_nxt  = gap;
        s_nxt     = i_r;
        e_nxt     = j_r;
        found_nxt = 1'b1;
      end
      if (last_j) begin
        if (last_i) begin
          active_nxt = 1'b0;
          done_nxt   = 1'b1;
        end else begin
          i_nxt = i_r + POS_W'(1);
          j_nxt = i_r + POS_W'(2);
        end
      end else begin
        j_nxt = j_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
    end
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    best_r  <= best_nxt;
    s_r     <= s_nxt;
    e_r     <= e_nxt;
    found_r <= found_nxt;
  end

  assign done          = done_r;
  assign res.found     = found_r;
  assign res.start_pos = s_r;
  assign res.end_pos   = e_r;
  assign res.span      = best_r;

endmodule
